// ===== sv/sata_dma_command_builder_macros.svh =====
// Assertion macros shared by the checker of the SATA DMA command builder.
`ifndef SATA_DMA_COMMAND_BUILDER_MACROS_SVH
`define SATA_DMA_COMMAND_BUILDER_MACROS_SVH

// Same-cycle implication, sampled on clock and disabled during reset.
`define SDCB_ASSERT_IMPLY(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("sdcb assertion failed");

// Next-cycle implication, sampled on clock and disabled during reset.
`define SDCB_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("sdcb assertion failed");

`endif

// ===== sv/sdcb_pkg.sv =====
// Package with the constants, types and codes of the SATA DMA command builder.
package sdcb_pkg;

   localparam int MAX_ENTRIES  = 8;
   localparam int CHUNK_BYTES  = 8192;
   localparam int SLOT_COUNT   = 32;
   localparam int SECTOR_BYTES = 512;

   localparam int OPCODE_W      = 1;
   localparam int LBA_W         = 48;
   localparam int SECTOR_CNT_W  = 16;
   localparam int ADDR_W        = 64;
   localparam int BUSY_W        = 32;
   localparam int KIND_W        = 2;
   localparam int SLOT_W        = 5;
   localparam int ENTRY_INDEX_W = 3;
   localparam int COUNT_WORD_W  = 32;
   localparam int ENTRY_TOTAL_W = 4;
   localparam int ATA_CMD_W     = 8;

   // Derived widths. CHUNK_BYTES and SECTOR_BYTES are powers of two.
   localparam int SECTOR_SHIFT = $clog2(SECTOR_BYTES);
   localparam int CHUNK_SHIFT  = $clog2(CHUNK_BYTES);
   localparam int BYTES_W      = SECTOR_CNT_W + SECTOR_SHIFT;
   localparam int CHUNKS_W     = BYTES_W + 1;
   localparam int TOTAL_W      = $clog2(MAX_ENTRIES + 1);
   localparam int IDX_W        = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int SIZE_W       = CHUNK_SHIFT + 1;

   localparam logic [ADDR_W-1:0]    PHYS_OFFSET = 64'hFFFF_FF00_0000_0000;
   localparam logic [ATA_CMD_W-1:0] ATA_READ_DMA_EXT  = 8'h25;
   localparam logic [ATA_CMD_W-1:0] ATA_WRITE_DMA_EXT = 8'h35;
   localparam int FINAL_BIT = COUNT_WORD_W - 1;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [KIND_W-1:0] {
      KIND_ENTRY    = 2'd0,
      KIND_COMMAND  = 2'd1,
      KIND_NO_SLOT  = 2'd2,
      KIND_TOO_MANY = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      BACK_IDLE,
      BACK_ENTRY,
      BACK_CMD,
      BACK_ERROR
   } back_state_type;

   // Classified request as it travels from the front to the back.
   typedef struct packed {
      kind_type                 status;
      logic [SLOT_W-1:0]        slot;
      logic [TOTAL_W-1:0]       total;
      logic [SIZE_W-1:0]        last_size;
      logic [ADDR_W-1:0]        phys;
      logic [OPCODE_W-1:0]      opcode;
      logic [LBA_W-1:0]         lba;
      logic [SECTOR_CNT_W-1:0]  sector_count;
   } desc_type;

   typedef struct packed {
      logic     valid;
      desc_type desc;
   } push_type;

   typedef struct packed {
      logic     valid;
      desc_type desc;
   } head_type;

   typedef struct packed {
      kind_type                  kind;
      logic [SLOT_W-1:0]         slot;
      logic [ENTRY_INDEX_W-1:0]  entry_index;
      logic [ADDR_W-1:0]         data_address;
      logic [COUNT_WORD_W-1:0]   count_word;
      logic [ENTRY_TOTAL_W-1:0]  entry_total;
      logic [ATA_CMD_W-1:0]      ata_command;
      logic [LBA_W-1:0]          lba_out;
      logic [SECTOR_CNT_W-1:0]   count_out;
      logic                      last;
   } rsp_payload_type;

endpackage

// ===== sv/sdcb_if.sv =====
// Request and response channel interfaces of the SATA DMA command builder.
interface sdcb_req_if;
   import sdcb_pkg::*;

   logic                     valid;
   logic                     ready;
   logic [OPCODE_W-1:0]      opcode;
   logic [LBA_W-1:0]         lba;
   logic [SECTOR_CNT_W-1:0]  sector_count;
   logic [ADDR_W-1:0]        buffer_address;
   logic [BUSY_W-1:0]        busy_slots;

   modport source (output valid, opcode, lba, sector_count, buffer_address, busy_slots,
                   input ready);
   modport sink (input valid, opcode, lba, sector_count, buffer_address, busy_slots,
                 output ready);
endinterface

interface sdcb_rsp_if;
   import sdcb_pkg::*;

   logic                      valid;
   logic                      ready;
   logic [KIND_W-1:0]         kind;
   logic [SLOT_W-1:0]         slot;
   logic [ENTRY_INDEX_W-1:0]  entry_index;
   logic [ADDR_W-1:0]         data_address;
   logic [COUNT_WORD_W-1:0]   count_word;
   logic [ENTRY_TOTAL_W-1:0]  entry_total;
   logic [ATA_CMD_W-1:0]      ata_command;
   logic [LBA_W-1:0]          lba_out;
   logic [SECTOR_CNT_W-1:0]   count_out;
   logic                      last;

   modport source (output valid, kind, slot, entry_index, data_address, count_word,
                   entry_total, ata_command, lba_out, count_out, last,
                   input ready);
   modport sink (input valid, kind, slot, entry_index, data_address, count_word,
                 entry_total, ata_command, lba_out, count_out, last,
                 output ready);
endinterface

// ===== sv/sdcb_front.sv =====
// Front end: accepts requests, finds the free slot and classifies the transfer.
module sdcb_front (
   sdcb_req_if.sink          req_if,
   input  logic              queue_full,
   output sdcb_pkg::push_type push
);
   import sdcb_pkg::*;

   logic [SLOT_W-1:0]    slot;
   logic                 slot_found;
   logic [BYTES_W-1:0]   bytes;
   logic [CHUNKS_W-1:0]  chunks;
   logic [CHUNK_SHIFT-1:0] rem;
   logic                 too_many;

   // Lowest clear bit of the busy mask; scanning downward leaves the lowest hit.
   always_comb begin
      slot       = '0;
      slot_found = 1'b0;
      for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
         if (!req_if.busy_slots[i]) begin
            slot       = SLOT_W'(i);
            slot_found = 1'b1;
         end
      end
   end

   assign bytes    = {req_if.sector_count, {SECTOR_SHIFT{1'b0}}};
   assign chunks   = CHUNKS_W'((CHUNKS_W'(bytes) + CHUNKS_W'(CHUNK_BYTES - 1)) >> CHUNK_SHIFT);
   assign rem      = bytes[CHUNK_SHIFT-1:0];
   assign too_many = chunks > CHUNKS_W'(MAX_ENTRIES);

   assign req_if.ready = !queue_full;

   always_comb begin
      push.valid             = req_if.valid && !queue_full;
      push.desc.status       = !slot_found ? KIND_NO_SLOT :
                               too_many    ? KIND_TOO_MANY : KIND_COMMAND;
      push.desc.slot         = slot;
      push.desc.total        = TOTAL_W'(chunks);
      push.desc.last_size    = (rem == '0) ? SIZE_W'(CHUNK_BYTES) : SIZE_W'(rem);
      push.desc.phys         = req_if.buffer_address - PHYS_OFFSET;
      push.desc.opcode       = req_if.opcode;
      push.desc.lba          = req_if.lba;
      push.desc.sector_count = req_if.sector_count;
   end

endmodule

// ===== sv/sdcb_queue.sv =====
// Short queue of classified requests between the front and the back end.
module sdcb_queue (
   input  logic               clock,
   input  logic               reset,
   input  sdcb_pkg::push_type push,
   input  logic               pop,
   output logic               full,
   output sdcb_pkg::head_type head
);
   import sdcb_pkg::*;

   desc_type            entries_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   logic                do_pop;

   assign full   = count_ff == QCNT_W'(QUEUE_DEPTH);
   assign do_pop = pop && (count_ff != '0);

   assign head.valid = count_ff != '0;
   assign head.desc  = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push.valid) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({push.valid, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.valid) begin
         entries_ff[wr_ptr_ff] <= push.desc;
      end
   end

endmodule

// ===== sv/sdcb_back.sv =====
// Back end: walks the scatter entries of one request and emits the command.
module sdcb_back (
   input  logic               clock,
   input  logic               reset,
   input  sdcb_pkg::head_type head,
   output logic               pop,
   sdcb_rsp_if.source         rsp_if
);
   import sdcb_pkg::*;

   back_state_type      state_ff, state_in;
   desc_type            work_ff, work_in;
   logic [IDX_W-1:0]    idx_ff, idx_in;
   logic [ADDR_W-1:0]   addr_ff, addr_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_payload_type     rsp_ff, rsp_in;

   logic                out_free;
   logic                is_final;
   logic [SIZE_W-1:0]   size;
   logic [COUNT_WORD_W-1:0] word;

   assign out_free = !rsp_valid_ff || rsp_if.ready;
   assign is_final = TOTAL_W'(idx_ff) == work_ff.total - 1'b1;
   assign size     = is_final ? work_ff.last_size : SIZE_W'(CHUNK_BYTES);

   // Byte-count word: size minus one, shifted up, with the low bit set and the top bit set on the final entry.
   always_comb begin
      word            = COUNT_WORD_W'({size - 1'b1, 1'b1});
      word[FINAL_BIT] = word[FINAL_BIT] | is_final;
   end

   always_comb begin
      state_in     = state_ff;
      work_in      = work_ff;
      idx_in       = idx_ff;
      addr_in      = addr_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      rsp_in       = rsp_ff;
      pop          = 1'b0;

      unique case (state_ff)
         BACK_IDLE: begin
            if (head.valid) begin
               pop     = 1'b1;
               work_in = head.desc;
               idx_in  = '0;
               addr_in = head.desc.phys;
               if (head.desc.status != KIND_COMMAND) begin
                  state_in = BACK_ERROR;
               end else if (head.desc.total == '0) begin
                  state_in = BACK_CMD;
               end else begin
                  state_in = BACK_ENTRY;
               end
            end
         end
         BACK_ENTRY: begin
            if (out_free) begin
               rsp_valid_in        = 1'b1;
               rsp_in              = '0;
               rsp_in.kind         = KIND_ENTRY;
               rsp_in.slot         = work_ff.slot;
               rsp_in.entry_index  = ENTRY_INDEX_W'(idx_ff);
               rsp_in.data_address = addr_ff;
               rsp_in.count_word   = word;
               rsp_in.entry_total  = ENTRY_TOTAL_W'(work_ff.total);
               idx_in              = idx_ff + 1'b1;
               addr_in             = addr_ff + ADDR_W'(CHUNK_BYTES);
               if (is_final) begin
                  state_in = BACK_CMD;
               end
            end
         end
         BACK_CMD: begin
            if (out_free) begin
               rsp_valid_in       = 1'b1;
               rsp_in             = '0;
               rsp_in.kind        = KIND_COMMAND;
               rsp_in.slot        = work_ff.slot;
               rsp_in.entry_total = ENTRY_TOTAL_W'(work_ff.total);
               rsp_in.ata_command = work_ff.opcode[0] ? ATA_WRITE_DMA_EXT : ATA_READ_DMA_EXT;
               rsp_in.lba_out     = work_ff.lba;
               rsp_in.count_out   = work_ff.sector_count;
               rsp_in.last        = 1'b1;
               state_in           = BACK_IDLE;
            end
         end
         BACK_ERROR: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_in       = '0;
               rsp_in.kind  = work_ff.status;
               rsp_in.slot  = work_ff.slot;
               rsp_in.last  = 1'b1;
               state_in     = BACK_IDLE;
            end
         end
         default: begin
            state_in = BACK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BACK_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      work_ff <= work_in;
      idx_ff  <= idx_in;
      addr_ff <= addr_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.kind         = rsp_ff.kind;
   assign rsp_if.slot         = rsp_ff.slot;
   assign rsp_if.entry_index  = rsp_ff.entry_index;
   assign rsp_if.data_address = rsp_ff.data_address;
   assign rsp_if.count_word   = rsp_ff.count_word;
   assign rsp_if.entry_total  = rsp_ff.entry_total;
   assign rsp_if.ata_command  = rsp_ff.ata_command;
   assign rsp_if.lba_out      = rsp_ff.lba_out;
   assign rsp_if.count_out    = rsp_ff.count_out;
   assign rsp_if.last         = rsp_ff.last;

endmodule

// ===== sv/sata_dma_command_builder.sv =====
// Top level of the SATA DMA command builder: front end, request queue, back end.
//
//   Channel   Direction  Carries
//   req_if    in         opcode, lba, sector_count, buffer_address, busy_slots
//   rsp_if    out        scatter entries, then one command or error item, last on the final
//
// In the back end a request is loaded, then walks its scatter entries one by one and
// ends with the command item; an error is loaded and then reported as a single item.
// The front classifies in the cycle of acceptance; the queue holds two requests.
// Reset is synchronous and clears the queue, the walker state and the output valid.
// Each side stalls on its own; the output register holds an item until it is taken.
module sata_dma_command_builder (
   input  logic       clock,
   input  logic       reset,
   sdcb_req_if.sink   req_if,
   sdcb_rsp_if.source rsp_if
);
   import sdcb_pkg::*;

   push_type push;
   head_type head;
   logic     queue_full;
   logic     pop;

   sdcb_front u_front (
      .req_if     (req_if),
      .queue_full (queue_full),
      .push       (push)
   );

   sdcb_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .pop   (pop),
      .full  (queue_full),
      .head  (head)
   );

   sdcb_back u_back (
      .clock  (clock),
      .reset  (reset),
      .head   (head),
      .pop    (pop),
      .rsp_if (rsp_if)
   );

endmodule

// ===== sv/sdcb_checker.sv =====
// Port-level checker of the SATA DMA command builder and its bind.
`include "sata_dma_command_builder_macros.svh"

module sdcb_checker (
   input logic        clock,
   input logic        reset,
   sdcb_req_if.sink   req_if,
   sdcb_rsp_if.source rsp_if
);
   import sdcb_pkg::*;

   logic req_take;
   logic entry_seen;

   assign req_take   = req_if.valid && req_if.ready;
   assign entry_seen = rsp_if.valid && (rsp_if.kind == KIND_ENTRY);

   `SDCB_ASSERT_NEXT(a_rsp_hold, rsp_if.valid && !rsp_if.ready, rsp_if.valid && $stable(rsp_if.kind) && $stable(rsp_if.data_address))
   `SDCB_ASSERT_IMPLY(a_final_kinds, rsp_if.valid && (rsp_if.kind != KIND_ENTRY), rsp_if.last)
   `SDCB_ASSERT_IMPLY(a_entry_shape, entry_seen, !rsp_if.last && rsp_if.count_word[0] && (ENTRY_TOTAL_W'(rsp_if.entry_index) < rsp_if.entry_total))
   `SDCB_ASSERT_IMPLY(a_reset_quiet, $past(reset), !rsp_if.valid)
   `SDCB_ASSERT_NEXT(a_no_early_rsp, $past(reset) && !req_take, !rsp_if.valid)

endmodule

bind sata_dma_command_builder sdcb_checker u_sdcb_checker (
   .clock  (clock),
   .reset  (reset),
   .req_if (req_if),
   .rsp_if (rsp_if)
);

// ===== tb/sv/dma_slot_check_pkg.sv =====
// Request type and result scoreboard for the SATA DMA command builder testbench.
`timescale 1ns / 1ps

package dma_slot_check_pkg;
   import sdcb_pkg::*;

   typedef struct packed {
      logic [OPCODE_W-1:0]     opcode;
      logic [LBA_W-1:0]        lba;
      logic [SECTOR_CNT_W-1:0] sector_count;
      logic [ADDR_W-1:0]       buffer_address;
      logic [BUSY_W-1:0]       busy_slots;
   } dma_request;

   class command_slot_scoreboard;
      rsp_payload_type awaited_items[$];
      int mismatches;
      int items_checked;
      int kind_seen[4];

      function new();
         mismatches = 0;
         items_checked = 0;
         kind_seen = '{0, 0, 0, 0};
      endfunction

      // Works out the scatter entries and the command (or the single error item)
      // that one accepted request should produce, and queues them in order.
      function void note_request(dma_request rq);
         rsp_payload_type   item;
         logic [ADDR_W-1:0] phys;
         logic [SLOT_W-1:0] slot;
         bit                found;
         int                bytes;
         int                chunks;
         int                left;
         int                size;
         int                i;
         found = 1'b0;
         slot = '0;
         // Scan downward so that the lowest free slot is the one kept.
         for (i = SLOT_COUNT - 1; i >= 0; i--) begin
            if (!rq.busy_slots[i]) begin
               slot = SLOT_W'(i);
               found = 1'b1;
            end
         end
         item = '0;
         item.last = 1'b1;
         if (!found) begin
            item.kind = KIND_NO_SLOT;
            awaited_items.push_back(item);
            return;
         end
         bytes = int'(rq.sector_count) * SECTOR_BYTES;
         chunks = (bytes + CHUNK_BYTES - 1) / CHUNK_BYTES;
         item.slot = slot;
         if (chunks > MAX_ENTRIES) begin
            item.kind = KIND_TOO_MANY;
            awaited_items.push_back(item);
            return;
         end
         phys = rq.buffer_address - PHYS_OFFSET;
         left = bytes;
         for (i = 0; i < chunks; i++) begin
            size = (left < CHUNK_BYTES) ? left : CHUNK_BYTES;
            item = '0;
            item.kind = KIND_ENTRY;
            item.slot = slot;
            item.entry_index = ENTRY_INDEX_W'(i);
            item.data_address = phys + ADDR_W'(CHUNK_BYTES) * ADDR_W'(i);
            item.count_word = COUNT_WORD_W'(((size - 1) << 1) | 1);
            if (i == chunks - 1) item.count_word[FINAL_BIT] = 1'b1;
            item.entry_total = ENTRY_TOTAL_W'(chunks);
            awaited_items.push_back(item);
            left -= size;
         end
         item = '0;
         item.kind = KIND_COMMAND;
         item.slot = slot;
         item.entry_total = ENTRY_TOTAL_W'(chunks);
         item.ata_command = rq.opcode ? ATA_WRITE_DMA_EXT : ATA_READ_DMA_EXT;
         item.lba_out = rq.lba;
         item.count_out = rq.sector_count;
         item.last = 1'b1;
         awaited_items.push_back(item);
      endfunction

      function void compare_field(string name, logic [63:0] want, logic [63:0] seen);
         if (seen !== want) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, seen);
         end
      endfunction

      function void check_result(rsp_payload_type got);
         rsp_payload_type want;
         if (awaited_items.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected item, expected none, actual %h", $time, got);
            return;
         end
         want = awaited_items.pop_front();
         items_checked++;
         kind_seen[int'(want.kind)]++;
         compare_field("kind", 64'(want.kind), 64'(got.kind));
         compare_field("slot", 64'(want.slot), 64'(got.slot));
         compare_field("entry_index", 64'(want.entry_index), 64'(got.entry_index));
         compare_field("data_address", want.data_address, got.data_address);
         compare_field("count_word", 64'(want.count_word), 64'(got.count_word));
         compare_field("entry_total", 64'(want.entry_total), 64'(got.entry_total));
         compare_field("ata_command", 64'(want.ata_command), 64'(got.ata_command));
         compare_field("lba_out", 64'(want.lba_out), 64'(got.lba_out));
         compare_field("count_out", 64'(want.count_out), 64'(got.count_out));
         compare_field("last", 64'(want.last), 64'(got.last));
      endfunction
   endclass

endpackage

// ===== tb/sv/tb_top.sv =====
// Top-level testbench: drives DMA requests into the command builder and checks every item.
`timescale 1ns / 1ps

module tb_top;
   import sdcb_pkg::*;
   import dma_slot_check_pkg::*;

   localparam int STALL_LIMIT  = 2000;
   localparam int LONG_HOLD    = 300;
   localparam int RANDOM_ITEMS = 444;
   localparam int DRAIN_CYCLES = 16;

   logic clock;
   logic reset;

   sdcb_req_if req_if ();
   sdcb_rsp_if rsp_if ();

   sata_dma_command_builder dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   command_slot_scoreboard sb = new();

   int send_idle_pct;
   int recv_idle_pct;
   int hold_requests;
   int hold_served;
   int requests_sent;
   int stall_cycles;

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // Receiver side: random back-pressure, plus a long hold-off whenever one is asked for.
   initial begin
      hold_served = 0;
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_served != hold_requests) begin
            hold_served = hold_requests;
            rsp_if.ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end else begin
            rsp_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      rsp_payload_type got;
      if (!reset && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
         got.kind = kind_type'(rsp_if.kind);
         got.slot = rsp_if.slot;
         got.entry_index = rsp_if.entry_index;
         got.data_address = rsp_if.data_address;
         got.count_word = rsp_if.count_word;
         got.entry_total = rsp_if.entry_total;
         got.ata_command = rsp_if.ata_command;
         got.lba_out = rsp_if.lba_out;
         got.count_out = rsp_if.count_out;
         got.last = rsp_if.last;
         sb.check_result(got);
      end
   end

   // Watchdog: any cycle without a handshake on either side counts toward the limit.
   initial begin
      stall_cycles = 0;
      while (reset !== 1'b0) @(posedge clock);
      while (stall_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_if.valid === 1'b1 && req_if.ready === 1'b1) ||
             (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1))
            stall_cycles = 0;
         else
            stall_cycles++;
      end
      $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
      $display("tb_top: errors");
      $finish;
   end

   function automatic dma_request make_request(logic [OPCODE_W-1:0] opcode,
                                               logic [LBA_W-1:0] lba,
                                               logic [SECTOR_CNT_W-1:0] sectors,
                                               logic [ADDR_W-1:0] buffer,
                                               logic [BUSY_W-1:0] busy);
      dma_request rq;
      rq.opcode = opcode;
      rq.lba = lba;
      rq.sector_count = sectors;
      rq.buffer_address = buffer;
      rq.busy_slots = busy;
      return rq;
   endfunction

   // Mostly transfers that fit the table, with the slot spread over the whole mask.
   function automatic dma_request random_request();
      dma_request rq;
      int         pick;
      int         free_bit;
      rq.opcode = 1'($urandom);
      rq.lba = {16'($urandom), 32'($urandom)};
      pick = $urandom_range(0, 99);
      if (pick < 8) rq.sector_count = '0;
      else if (pick < 68) rq.sector_count = 16'($urandom_range(1, 128));
      else if (pick < 80) rq.sector_count = 16'($urandom_range(112, 144));
      else if (pick < 96) rq.sector_count = 16'($urandom);
      else rq.sector_count = 16'hFFFF;
      pick = $urandom_range(0, 99);
      if (pick < 60) rq.buffer_address = {32'($urandom), 32'($urandom)};
      else if (pick < 80) rq.buffer_address = PHYS_OFFSET + 64'($urandom_range(0, 1 << 20));
      else rq.buffer_address = 64'($urandom_range(0, 65535));
      free_bit = $urandom_range(0, 35);
      if (free_bit >= BUSY_W) begin
         rq.busy_slots = '1;
      end else begin
         rq.busy_slots = 32'($urandom) | ((32'd1 << free_bit) - 32'd1);
         rq.busy_slots[free_bit] = 1'b0;
      end
      return rq;
   endfunction

   task automatic send_request(input dma_request rq);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.opcode <= rq.opcode;
      req_if.lba <= rq.lba;
      req_if.sector_count <= rq.sector_count;
      req_if.buffer_address <= rq.buffer_address;
      req_if.busy_slots <= rq.busy_slots;
      @(posedge clock);
      while (req_if.ready !== 1'b1) @(posedge clock);
      sb.note_request(rq);
      requests_sent++;
   endtask

   task automatic wait_until_drained();
      req_if.valid <= 1'b0;
      do @(posedge clock); while (sb.awaited_items.size() != 0);
   endtask

   task automatic send_random(input int count);
      repeat (count) send_request(random_request());
      wait_until_drained();
   endtask

   initial begin
      requests_sent = 0;
      hold_requests = 0;
      send_idle_pct = 20;
      recv_idle_pct = 51;
      reset <= 1'b1;
      req_if.valid <= 1'b0;
      req_if.opcode <= '0;
      req_if.lba <= '0;
      req_if.sector_count <= '0;
      req_if.buffer_address <= '0;
      req_if.busy_slots <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Zero sectors gives the command alone; the buffer at the offset maps to zero.
      send_request(make_request(1'b0, '0, 16'd0, PHYS_OFFSET, 32'h0000_0000));
      send_request(make_request(1'b1, '1, 16'd1, '1, 32'h7FFF_FFFF));
      // A buffer below the offset wraps around the top of the address space.
      send_request(make_request(1'b0, 48'h0000_0000_0001, 16'd16, '0, 32'hFFFF_FFFE));
      send_request(make_request(1'b1, 48'h1234_5678_9ABC, 16'd17, 64'hFFFF_FF80_0000_0000,
                                32'h0000_0003));
      send_request(make_request(1'b0, 48'h8000_0000_0000, 16'd128, 64'hFFFF_FFFF_FFFF_E000,
                                32'h0000_00FF));
      send_request(make_request(1'b1, 48'h7FFF_FFFF_FFFF, 16'd127, PHYS_OFFSET - 64'd1,
                                32'hAAAA_AAAA));
      send_request(make_request(1'b0, 48'hFFFF_0000_FFFF, 16'd15, 64'h0123_4567_89AB_CDEF,
                                32'h5555_5555));
      // Too many entries, with the slot still reported.
      send_request(make_request(1'b1, 48'h0000_FFFF_0000, 16'd129, PHYS_OFFSET,
                                32'h0000_001F));
      send_request(make_request(1'b0, '1, 16'hFFFF, '1, 32'h0000_0000));
      send_request(make_request(1'b1, '0, 16'h8000, '0, 32'h7FFF_FFFF));
      // A full busy mask wins over an oversized transfer and over an empty one.
      send_request(make_request(1'b0, '1, 16'hFFFF, '1, 32'hFFFF_FFFF));
      send_request(make_request(1'b1, '0, 16'd0, '0, 32'hFFFF_FFFF));
      send_request(make_request(1'b1, 48'h8000_0000_0000, 16'd112, 64'hFFFF_FF00_FFFF_0000,
                                32'h0000_FFFF));
      send_request(make_request(1'b0, 48'h5555_5555_5555, 16'd8, 64'hAAAA_AAAA_AAAA_AAAA,
                                32'hFFFF_0000));
      send_request(make_request(1'b1, 48'hAAAA_AAAA_AAAA, 16'd113, 64'h5555_5555_5555_5555,
                                32'hBFFF_FFFF));
      send_request(make_request(1'b0, 48'h0000_0000_0200, 16'd96, 64'h8000_0000_0000_0000,
                                32'hFFFE_FFFF));
      wait_until_drained();

      send_random(RANDOM_ITEMS / 3);
      send_idle_pct = 51;
      recv_idle_pct = 20;
      send_random(RANDOM_ITEMS / 3);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      // The receiver stops for a long stretch while requests keep coming.
      hold_requests++;
      send_random(RANDOM_ITEMS - 2 * (RANDOM_ITEMS / 3));
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("tb_top: %0d requests, %0d items checked: %0d entries, %0d commands, %0d no-slot, %0d oversized",
               requests_sent, sb.items_checked, sb.kind_seen[KIND_ENTRY],
               sb.kind_seen[KIND_COMMAND], sb.kind_seen[KIND_NO_SLOT],
               sb.kind_seen[KIND_TOO_MANY]);
      $display("tb_top: idling sender/receiver 20/51, 51/20, none, with a %0d-cycle receiver hold",
               LONG_HOLD);
      if (sb.awaited_items.size() != 0)
         $display("%0t: %0d items still expected", $time, sb.awaited_items.size());
      if (sb.mismatches == 0 && sb.awaited_items.size() == 0) begin
         $display("tb_top: clean");
      end else begin
         $display("tb_top: errors");
      end
      $finish;
   end

endmodule
